FILE: rtl/mtbl_pkg.sv
`default_nettype none

package mtbl_pkg;

    // Operation codes carried in the func field.
    localparam logic [2:0] FN_ALLOC  = 3'd0;
    localparam logic [2:0] FN_FREE   = 3'd1;
    localparam logic [2:0] FN_TICK   = 3'd2;
    localparam logic [2:0] FN_FETCH  = 3'd3;
    localparam logic [2:0] FN_RETURN = 3'd4;
    localparam logic [2:0] FN_CHECK  = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_UNUSED = 2'd3;

    // Port field widths.
    localparam int FUNC_W   = 3;
    localparam int SLOT_W   = 6;
    localparam int FIELD_W  = 24;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 32;

    // One item as it travels down the row of cells, with its result so far.
    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [SLOT_W-1:0]   slot;
        logic [FIELD_W-1:0]  amount;
        logic [FIELD_W-1:0]  rate;
        logic [FIELD_W-1:0]  burst;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
        logic [FIELD_W-1:0]  tokens_out;
    } mtbl_item_t;

endpackage

`default_nettype wire

FILE: rtl/mtbl_cell.sv
`default_nettype none

module mtbl_cell #(
    parameter int INDEX       = 0,
    parameter int TOKEN_WIDTH = 24
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      advance,
    input  wire                      in_valid,
    input  wire mtbl_pkg::mtbl_item_t in_item,
    output logic                     out_valid,
    output mtbl_pkg::mtbl_item_t     out_item
);
    import mtbl_pkg::*;

    logic                   valid_reg;
    mtbl_item_t             item_reg;
    mtbl_item_t             item_next;
    logic                   in_use_reg;
    logic                   in_use_next;
    logic [TOKEN_WIDTH-1:0] rate_reg;
    logic [TOKEN_WIDTH-1:0] rate_next;
    logic [TOKEN_WIDTH-1:0] ceil_reg;
    logic [TOKEN_WIDTH-1:0] ceil_next;
    logic [TOKEN_WIDTH-1:0] tokens_reg;
    logic [TOKEN_WIDTH-1:0] tokens_next;

    logic                   hit;
    logic [TOKEN_WIDTH-1:0] amount_tw;
    logic [TOKEN_WIDTH:0]   add_sum;
    logic [TOKEN_WIDTH-1:0] add_sat;
    logic [TOKEN_WIDTH-1:0] grant;

    // This cell owns the bucket whose index equals INDEX.
    assign hit       = (32'(in_item.slot) == INDEX);
    assign amount_tw = TOKEN_WIDTH'(in_item.amount);

    // Shared saturating adder: the rate on tick, the amount on return.
    always_comb begin
        if (in_item.func == FN_TICK) begin
            add_sum = {1'b0, tokens_reg} + {1'b0, rate_reg};
        end else begin
            add_sum = {1'b0, tokens_reg} + {1'b0, amount_tw};
        end
        add_sat = (add_sum > {1'b0, ceil_reg}) ? ceil_reg : add_sum[TOKEN_WIDTH-1:0];
    end

    assign grant = (tokens_reg < amount_tw) ? tokens_reg : amount_tw;

    // Apply the passing item to this bucket and update its result.
    always_comb begin
        item_next   = in_item;
        in_use_next = in_use_reg;
        rate_next   = rate_reg;
        ceil_next   = ceil_reg;
        tokens_next = tokens_reg;
        if (in_valid) begin
            unique case (in_item.func)
                FN_ALLOC: begin
                    // The first free cell that sees a still-pending allocate takes it.
                    if (in_item.status == ST_FULL && !in_use_reg) begin
                        in_use_next        = 1'b1;
                        rate_next          = TOKEN_WIDTH'(in_item.rate);
                        ceil_next          = TOKEN_WIDTH'(in_item.burst);
                        tokens_next        = '0;
                        item_next.status   = ST_OK;
                        item_next.slot_out = SLOT_W'(INDEX);
                    end
                end
                FN_FREE: begin
                    if (hit && in_use_reg) begin
                        in_use_next      = 1'b0;
                        item_next.status = ST_OK;
                    end
                end
                FN_TICK: begin
                    if (in_use_reg) begin
                        tokens_next = add_sat;
                    end
                end
                FN_FETCH: begin
                    if (hit && in_use_reg) begin
                        if (tokens_reg == '0) begin
                            item_next.status = ST_WAIT;
                        end else begin
                            item_next.status     = ST_OK;
                            item_next.tokens_out = FIELD_W'(grant);
                            tokens_next          = tokens_reg - grant;
                        end
                    end
                end
                FN_RETURN: begin
                    if (hit && in_use_reg) begin
                        item_next.status = ST_OK;
                        tokens_next      = add_sat;
                    end
                end
                FN_CHECK: begin
                    if (hit && in_use_reg) begin
                        item_next.status     = ST_OK;
                        item_next.tokens_out = FIELD_W'(tokens_reg);
                    end
                end
                default: begin
                    item_next = in_item;
                end
            endcase
        end
    end

    // Control state: item valid and bucket in-use flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            in_use_reg <= 1'b0;
        end else if (advance) begin
            valid_reg  <= in_valid;
            in_use_reg <= in_use_next;
        end
    end

    // Payload and bucket contents.
    always_ff @(posedge aclk) begin
        if (advance) begin
            item_reg   <= item_next;
            rate_reg   <= rate_next;
            ceil_reg   <= ceil_next;
            tokens_reg <= tokens_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

FILE: rtl/multi_token_bucket_limiter.sv
`default_nettype none

// Channel   Direction  Ports                        Contents
// s_        in         s_tvalid s_tready s_tdata    one operation item
// m_        out        m_tvalid m_tready m_tdata    one result item per operation
//
// Each item walks the row of NUM_BUCKETS cells, one cell per cycle while the row
// advances, and its result leaves the last cell; a new item enters on each such cycle.
// The whole row advances together; it holds while a result waits on m_tready.
// The last cell's registers are the output register.
// Reset clears the in-use flags and valid bits; bucket contents need no reset.

module multi_token_bucket_limiter #(
    parameter int NUM_BUCKETS = 64,
    parameter int TOKEN_WIDTH = 24
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // func[2:0], slot[8:3], amount[32:9], rate[56:33], burst[80:57], zeros[87:81]
    input  wire  [mtbl_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // status[1:0], slot_out[7:2], tokens_out[31:8]
    output logic [mtbl_pkg::M_DATA_W-1:0]    m_tdata
);
    import mtbl_pkg::*;

    logic       advance;
    mtbl_item_t entry_item;
    logic       chain_valid [NUM_BUCKETS+1];
    mtbl_item_t chain_item  [NUM_BUCKETS+1];

    // The row moves whenever the output register is empty or being taken.
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    // Unpack the entering item and preset the result each operation starts from.
    always_comb begin
        entry_item.func       = s_tdata[2:0];
        entry_item.slot       = s_tdata[8:3];
        entry_item.amount     = s_tdata[32:9];
        entry_item.rate       = s_tdata[56:33];
        entry_item.burst      = s_tdata[80:57];
        entry_item.slot_out   = s_tdata[8:3];
        entry_item.tokens_out = '0;
        unique case (s_tdata[2:0])
            FN_ALLOC: begin
                entry_item.status   = ST_FULL;
                entry_item.slot_out = '0;
            end
            FN_FREE, FN_FETCH, FN_RETURN, FN_CHECK: begin
                entry_item.status = ST_UNUSED;
            end
            default: begin
                entry_item.status = ST_OK;
            end
        endcase
    end

    assign chain_valid[0] = s_tvalid;
    assign chain_item[0]  = entry_item;

    // One cell per bucket.
    for (genvar i = 0; i < NUM_BUCKETS; i++) begin : g_cell
        mtbl_cell #(
            .INDEX       (i),
            .TOKEN_WIDTH (TOKEN_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (chain_valid[i]),
            .in_item   (chain_item[i]),
            .out_valid (chain_valid[i+1]),
            .out_item  (chain_item[i+1])
        );
    end

    assign m_tvalid = chain_valid[NUM_BUCKETS];
    assign m_tdata  = {chain_item[NUM_BUCKETS].tokens_out,
                       chain_item[NUM_BUCKETS].slot_out,
                       chain_item[NUM_BUCKETS].status};

endmodule

`default_nettype wire
